[rtl/spiral_lsb_message_extractor_top_defines.svh]
// Assertion macros shared by the spiral extractor checker.
`ifndef SPIRAL_LSB_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH
`define SPIRAL_LSB_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SLX_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slx assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SLX_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slx assertion failed");

`endif

[rtl/slx_pkg.sv]
// Package: types, constants and helpers for the spiral low-bit extractor.
`timescale 1ns / 1ps
package slx_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MAGIC_MAX  = 8;
   localparam int QDEPTH     = MAGIC_MAX + 1;

   localparam int DIM_W      = 13;
   localparam int POS_W      = 12;
   localparam int LEG_W      = 13;
   localparam int PIX_W      = 8;
   localparam int BPP_W      = 4;
   localparam int BIDX_W     = 3;
   localparam int MAGIC_W    = 64;
   localparam int MLEN_W     = 4;
   localparam int LIMIT_W    = 20;
   localparam int FILL_W     = 4;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMG_WIDTH       = 4'd0,
      REG_IMG_HEIGHT      = 4'd1,
      REG_BITS_PER_PIXEL  = 4'd2,
      REG_START_BIT_INDEX = 4'd3,
      REG_START_BYTE      = 4'd4,
      REG_MAGIC_WORD      = 4'd5,
      REG_MAGIC_LENGTH    = 4'd6,
      REG_PIXEL_LIMIT     = 4'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef struct packed {
      logic [DIM_W-1:0]   img_width;
      logic [DIM_W-1:0]   img_height;
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [BIDX_W-1:0]  start_bit_index;
      logic [PIX_W-1:0]   start_byte;
      logic [MAGIC_W-1:0] magic_word;
      logic [MLEN_W-1:0]  magic_length;
      logic [LIMIT_W-1:0] pixel_limit;
   } cfg_type;

   // current settings, settings after this cycle's write, and restart strobe
   typedef struct packed {
      cfg_type cur;
      cfg_type nxt;
      logic    restart;
   } cfg_bus_type;

   // everything one sample produces; bytes[0] goes out first
   typedef struct packed {
      logic [POS_W-1:0]              next_x;
      logic [POS_W-1:0]              next_y;
      logic                          walk_over;
      logic                          end_found;
      logic [PIX_W-1:0]              partial_byte;
      logic [BIDX_W-1:0]             bit_position;
      logic                          byte_valid;
      logic [CNT_W-1:0]              count;
      logic [QDEPTH-1:0][PIX_W-1:0]  bytes;
   } rsp_type;

   localparam cfg_type CFG_RESET = '{
      img_width:       13'd640,
      img_height:      13'd480,
      bits_per_pixel:  4'd1,
      start_bit_index: 3'd7,
      start_byte:      8'd0,
      magic_word:      64'd0,
      magic_length:    4'd1,
      pixel_limit:     20'd1000
   };

   // dimensions above MAX_DIM behave as MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
      return r;
   endfunction

   // spiral start: centre of the effective image
   function automatic logic [POS_W-1:0] centre(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] e;
      e = eff_dim(d);
      return e[DIM_W-1:1];
   endfunction

endpackage

[rtl/slx_csr.sv]
// Configuration register file with restart strobe.
`timescale 1ns / 1ps
module slx_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [slx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slx_pkg::CSR_DATA_W-1:0]     csr_data,
   output slx_pkg::cfg_bus_type               cfg_bus
);
   import slx_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    restart;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_IMG_WIDTH: begin
               cfg_in.img_width = csr_data[DIM_W-1:0];
               restart = 1'b1;
            end
            REG_IMG_HEIGHT: begin
               cfg_in.img_height = csr_data[DIM_W-1:0];
               restart = 1'b1;
            end
            REG_BITS_PER_PIXEL: begin
               cfg_in.bits_per_pixel = csr_data[BPP_W-1:0];
               restart = 1'b1;
            end
            REG_START_BIT_INDEX: begin
               cfg_in.start_bit_index = csr_data[BIDX_W-1:0];
               restart = 1'b1;
            end
            REG_START_BYTE: begin
               cfg_in.start_byte = csr_data[PIX_W-1:0];
               restart = 1'b1;
            end
            REG_MAGIC_WORD: begin
               cfg_in.magic_word = csr_data[MAGIC_W-1:0];
               restart = 1'b1;
            end
            REG_MAGIC_LENGTH: begin
               cfg_in.magic_length = csr_data[MLEN_W-1:0];
               restart = 1'b1;
            end
            REG_PIXEL_LIMIT: begin
               cfg_in.pixel_limit = csr_data[LIMIT_W-1:0];
               restart = 1'b1;
            end
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_bus.cur     = cfg_ff;
   assign cfg_bus.nxt     = cfg_in;
   assign cfg_bus.restart = restart;

endmodule

[rtl/slx_core.sv]
// Walk, bit packing and terminator window: state and per-sample logic.
`timescale 1ns / 1ps
module slx_core (
   input  logic                        clock,
   input  logic                        reset,
   input  slx_pkg::cfg_bus_type        cfg_bus,
   input  logic                        take,
   input  logic [slx_pkg::PIX_W-1:0]   pixel_value,
   output slx_pkg::rsp_type            rec
);
   import slx_pkg::*;

   logic [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic [LEG_W-1:0]   leg_len_ff, leg_len_in;
   logic [LEG_W-1:0]   leg_steps_ff, leg_steps_in;
   dir_type            dir_ff, dir_in;
   logic               first_ff, first_in;
   logic [PIX_W-1:0]   pack_byte_ff, pack_byte_in;
   logic [BIDX_W-1:0]  pack_idx_ff, pack_idx_in;
   logic [PIX_W-1:0]   win_ff [MAGIC_MAX];
   logic [PIX_W-1:0]   win_in [MAGIC_MAX];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [LIMIT_W-1:0] seen_ff, seen_in;
   logic               stopped_ff, stopped_in;
   logic               end_ff, end_in;

   cfg_type            cfg;
   logic [DIM_W-1:0]   eff_w, eff_h;
   logic [BPP_W-1:0]   bits;
   logic [MLEN_W-1:0]  len;

   assign cfg   = cfg_bus.cur;
   assign eff_w = eff_dim(cfg.img_width);
   assign eff_h = eff_dim(cfg.img_height);
   assign bits  = (cfg.bits_per_pixel > BPP_W'(8)) ? BPP_W'(8) : cfg.bits_per_pixel;
   assign len   = (cfg.magic_length > MLEN_W'(MAGIC_MAX)) ? MLEN_W'(MAGIC_MAX)
                                                          : cfg.magic_length;

   always_comb begin
      logic [PIX_W-1:0]             pb;
      logic [BIDX_W-1:0]            pi;
      logic                         done;
      logic [PIX_W-1:0]             cbyte;
      logic [FILL_W-1:0]            f;
      logic [CNT_W-1:0]             nob;
      logic [QDEPTH-1:0][PIX_W-1:0] obuf;
      logic [MAGIC_W-1:0]           m_al;
      logic [5:0]                   sh;
      logic                         mism;
      logic                         matched;
      logic                         oob;
      logic [POS_W-1:0]             nx, ny;
      logic [LEG_W-1:0]             steps1;

      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      leg_len_in   = leg_len_ff;
      leg_steps_in = leg_steps_ff;
      dir_in       = dir_ff;
      first_in     = first_ff;
      pack_byte_in = pack_byte_ff;
      pack_idx_in  = pack_idx_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      stopped_in   = stopped_ff;
      end_in       = end_ff;

      pb      = pack_byte_ff;
      pi      = pack_idx_ff;
      done    = 1'b0;
      cbyte   = '0;
      f       = fill_ff;
      nob     = '0;
      obuf    = '0;
      sh      = {3'(4'(MAGIC_MAX) - len), 3'b000};
      m_al    = cfg.magic_word << sh;
      mism    = 1'b0;
      matched = 1'b0;
      oob     = 1'b0;
      nx      = pos_x_ff;
      ny      = pos_y_ff;
      steps1  = leg_steps_ff + LEG_W'(1);

      if (stopped_ff) begin
         // walk is over: report only
      end else if (first_ff) begin
         // priming: sample ignored, centre already reported
         first_in = 1'b0;
         if (eff_w == '0 || eff_h == '0) begin
            stopped_in = 1'b1;
         end
      end else begin
         // low bits, MSB first; at most one byte completes per sample
         for (int i = PIX_W - 1; i >= 0; i--) begin
            if (BPP_W'(i) < bits) begin
               pb[pi] = pixel_value[i];
               if (pi == '0) begin
                  done  = 1'b1;
                  cbyte = pb;
                  pb    = '0;
                  pi    = BIDX_W'(7);
               end else begin
                  pi = pi - BIDX_W'(1);
               end
            end
         end

         if (done) begin
            if (len == '0) begin
               obuf[0] = cbyte;
               nob     = CNT_W'(1);
            end else begin
               if (f >= FILL_W'(len)) begin
                  obuf[0] = win_in[0];
                  nob     = CNT_W'(1);
                  for (int k = 0; k < MAGIC_MAX - 1; k++) begin
                     win_in[k] = win_in[k+1];
                  end
                  f = FILL_W'(len) - FILL_W'(1);
               end
               win_in[f[BIDX_W-1:0]] = cbyte;
               f = f + FILL_W'(1);
               // window k pairs with terminator byte len-1-k
               for (int k = 0; k < MAGIC_MAX; k++) begin
                  if (MLEN_W'(k) < len && win_in[k] != m_al[(MAGIC_MAX-1-k)*8 +: 8]) begin
                     mism = 1'b1;
                  end
               end
               matched = (f == FILL_W'(len)) && !mism;
            end
         end

         if (matched) begin
            // rest of the sample is dropped, window discarded
            end_in     = 1'b1;
            stopped_in = 1'b1;
            f          = '0;
            pb         = '0;
            pi         = BIDX_W'(7);
         end else begin
            seen_in = seen_ff + LIMIT_W'(1);
            if (seen_in >= cfg.pixel_limit) begin
               stopped_in = 1'b1;
            end else begin
               case (dir_ff)
                  DIR_UP: begin
                     oob = (pos_y_ff == '0);
                     ny  = pos_y_ff - POS_W'(1);
                  end
                  DIR_RIGHT: begin
                     oob = ({1'b0, pos_x_ff} + DIM_W'(1)) >= eff_w;
                     nx  = pos_x_ff + POS_W'(1);
                  end
                  DIR_DOWN: begin
                     oob = ({1'b0, pos_y_ff} + DIM_W'(1)) >= eff_h;
                     ny  = pos_y_ff + POS_W'(1);
                  end
                  DIR_LEFT: begin
                     oob = (pos_x_ff == '0);
                     nx  = pos_x_ff - POS_W'(1);
                  end
                  default: ;
               endcase
               if (steps1 >= leg_len_ff) begin
                  leg_steps_in = '0;
                  if (dir_ff[0]) begin
                     leg_len_in = leg_len_ff + LEG_W'(1);
                  end
                  dir_in = dir_type'(dir_ff + 2'd1);
               end else begin
                  leg_steps_in = steps1;
               end
               if (oob) begin
                  stopped_in = 1'b1;
               end else begin
                  pos_x_in = nx;
                  pos_y_in = ny;
               end
            end
            // walk ended without terminator: flush the window behind any byte
            if (stopped_in) begin
               for (int k = 0; k < MAGIC_MAX; k++) begin
                  if (FILL_W'(k) < f) begin
                     if (nob != '0) begin
                        obuf[k+1] = win_in[k];
                     end else begin
                        obuf[k] = win_in[k];
                     end
                  end
               end
               nob = nob + CNT_W'(f);
               f   = '0;
            end
         end
      end

      pack_byte_in = pb;
      pack_idx_in  = pi;
      fill_in      = f;

      rec.next_x       = stopped_in ? '0 : pos_x_in;
      rec.next_y       = stopped_in ? '0 : pos_y_in;
      rec.walk_over    = stopped_in;
      rec.end_found    = end_in;
      rec.partial_byte = pack_byte_in;
      rec.bit_position = pack_idx_in;
      rec.byte_valid   = (nob != '0);
      rec.count        = (nob == '0) ? CNT_W'(1) : nob;
      rec.bytes        = obuf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= centre(CFG_RESET.img_width);
         pos_y_ff     <= centre(CFG_RESET.img_height);
         leg_len_ff   <= LEG_W'(1);
         leg_steps_ff <= '0;
         dir_ff       <= DIR_UP;
         first_ff     <= 1'b1;
         pack_byte_ff <= CFG_RESET.start_byte;
         pack_idx_ff  <= CFG_RESET.start_bit_index;
         fill_ff      <= '0;
         seen_ff      <= '0;
         stopped_ff   <= 1'b0;
         end_ff       <= 1'b0;
      end else if (cfg_bus.restart) begin
         pos_x_ff     <= centre(cfg_bus.nxt.img_width);
         pos_y_ff     <= centre(cfg_bus.nxt.img_height);
         leg_len_ff   <= LEG_W'(1);
         leg_steps_ff <= '0;
         dir_ff       <= DIR_UP;
         first_ff     <= 1'b1;
         pack_byte_ff <= cfg_bus.nxt.start_byte;
         pack_idx_ff  <= cfg_bus.nxt.start_bit_index;
         fill_ff      <= '0;
         seen_ff      <= '0;
         stopped_ff   <= 1'b0;
         end_ff       <= 1'b0;
      end else if (take) begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         leg_len_ff   <= leg_len_in;
         leg_steps_ff <= leg_steps_in;
         dir_ff       <= dir_in;
         first_ff     <= first_in;
         pack_byte_ff <= pack_byte_in;
         pack_idx_ff  <= pack_idx_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         stopped_ff   <= stopped_in;
         end_ff       <= end_in;
      end
   end

   // window contents: only entries below the fill count are ever read
   always_ff @(posedge clock) begin
      if (take && !cfg_bus.restart) begin
         win_ff <= win_in;
      end
   end

endmodule

[rtl/slx_outq.sv]
// Result register with byte queue; one result per transfer.
`timescale 1ns / 1ps
module slx_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  slx_pkg::rsp_type              rec,
   input  logic                          rsp_ready,
   output logic                          can_take,
   output logic                          rsp_valid,
   output logic [slx_pkg::POS_W-1:0]     rsp_next_x,
   output logic [slx_pkg::POS_W-1:0]     rsp_next_y,
   output logic                          rsp_walk_over,
   output logic                          rsp_end_found,
   output logic [slx_pkg::PIX_W-1:0]     rsp_byte_out,
   output logic                          rsp_byte_valid,
   output logic [slx_pkg::PIX_W-1:0]     rsp_partial_byte,
   output logic [slx_pkg::BIDX_W-1:0]    rsp_bit_position,
   output logic                          rsp_is_last
);
   import slx_pkg::*;

   logic                         valid_ff, valid_in;
   rsp_type                      rec_ff, rec_in;
   logic                         last;
   logic                         pop;

   assign last     = (rec_ff.count == CNT_W'(1));
   assign pop      = valid_ff && rsp_ready;
   assign can_take = !valid_ff || (rsp_ready && last);

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (load) begin
         valid_in = 1'b1;
         rec_in   = rec;
      end else if (pop) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            rec_in.count = rec_ff.count - CNT_W'(1);
            for (int k = 0; k < QDEPTH - 1; k++) begin
               rec_in.bytes[k] = rec_ff.bytes[k+1];
            end
            rec_in.bytes[QDEPTH-1] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_next_x       = rec_ff.next_x;
   assign rsp_next_y       = rec_ff.next_y;
   assign rsp_walk_over    = rec_ff.walk_over;
   assign rsp_end_found    = rec_ff.end_found;
   assign rsp_byte_out     = rec_ff.byte_valid ? rec_ff.bytes[0] : '0;
   assign rsp_byte_valid   = rec_ff.byte_valid;
   assign rsp_partial_byte = rec_ff.partial_byte;
   assign rsp_bit_position = rec_ff.bit_position;
   assign rsp_is_last      = last;

endmodule

[rtl/spiral_lsb_message_extractor_top.sv]
// Top level of the spiral low-bit message extractor.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------
//   csr     | in  | csr_valid / csr_ready  | csr_index, csr_data (64b)
//   req     | in  | req_valid / req_ready  | req_pixel_value
//   rsp     | out | rsp_valid / rsp_ready  | rsp_next_x .. rsp_is_last (nine fields)
//
// Cycles: a sample is processed in the cycle it transfers; its results sit in
//   the result register from the next cycle. One sample per cycle while the
//   result side keeps up: a sample giving N results (N = 1, or up to 9 when
//   the walk ends and the delay window flushes) holds the result queue until
//   all N have left; the next sample transfers in the cycle the last leaves.
// Reset: synchronous, active high; restores the register defaults and
//   restarts the walk. A write to a mapped register also restarts the walk
//   (no clearing pass); a write to an unmapped index is dropped.
// Stalls: req_ready follows the result queue, never the walk state.
`timescale 1ns / 1ps
module spiral_lsb_message_extractor_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [slx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slx_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [slx_pkg::PIX_W-1:0]     req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [slx_pkg::POS_W-1:0]     rsp_next_x,
   output logic [slx_pkg::POS_W-1:0]     rsp_next_y,
   output logic                          rsp_walk_over,
   output logic                          rsp_end_found,
   output logic [slx_pkg::PIX_W-1:0]     rsp_byte_out,
   output logic                          rsp_byte_valid,
   output logic [slx_pkg::PIX_W-1:0]     rsp_partial_byte,
   output logic [slx_pkg::BIDX_W-1:0]    rsp_bit_position,
   output logic                          rsp_is_last
);
   import slx_pkg::*;

   cfg_bus_type cfg_bus;
   rsp_type     rec;
   logic        can_take;
   logic        take;

   // registers are always writable; the user must write only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   assign req_ready = can_take;
   assign take      = req_valid && can_take;

   slx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_bus   (cfg_bus)
   );

   // walk/pack/window state; rec is this cycle's sample outcome
   slx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg_bus     (cfg_bus),
      .take        (take),
      .pixel_value (req_pixel_value),
      .rec         (rec)
   );

   // result register plus byte queue for window flushes
   slx_outq u_outq (
      .clock            (clock),
      .reset            (reset),
      .load             (take),
      .rec              (rec),
      .rsp_ready        (rsp_ready),
      .can_take         (can_take),
      .rsp_valid        (rsp_valid),
      .rsp_next_x       (rsp_next_x),
      .rsp_next_y       (rsp_next_y),
      .rsp_walk_over    (rsp_walk_over),
      .rsp_end_found    (rsp_end_found),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_partial_byte (rsp_partial_byte),
      .rsp_bit_position (rsp_bit_position),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

[rtl/slx_checker.sv]
// Port-level checker for the spiral extractor, bound to the top level.
`timescale 1ns / 1ps
`include "spiral_lsb_message_extractor_top_defines.svh"
module slx_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [slx_pkg::POS_W-1:0]     rsp_next_x,
   input  logic [slx_pkg::POS_W-1:0]     rsp_next_y,
   input  logic                          rsp_walk_over,
   input  logic                          rsp_end_found,
   input  logic                          rsp_byte_valid,
   input  logic                          rsp_is_last
);
   import slx_pkg::*;

   // a new sample only enters when no result is pending or as the final pending result leaves
   `SLX_ASSERT_IMP(a_take_when_free, req_valid && req_ready, !rsp_valid || (rsp_ready && rsp_is_last))
   // a stopped walk reports no position
   `SLX_ASSERT_IMP(a_stop_pos_zero, rsp_valid && rsp_walk_over, rsp_next_x == '0 && rsp_next_y == '0)
   `SLX_ASSERT_IMP(a_end_stops, rsp_valid && rsp_end_found, rsp_walk_over)
   // only byte-carrying results come in bursts
   `SLX_ASSERT_IMP(a_burst_bytes, rsp_valid && !rsp_is_last, rsp_byte_valid)
   `SLX_ASSERT_NXT(a_burst_cont, rsp_valid && rsp_ready && !rsp_is_last, rsp_valid)

endmodule

bind spiral_lsb_message_extractor_top slx_checker u_slx_checker (.*);

[tb/sv/spiral_lsb_message_extractor_top_tb.sv]
// Self-checking testbench for the spiral low-bit message extractor top level.
`timescale 1ns / 1ps
module spiral_lsb_message_extractor_top_tb;
   import slx_pkg::*;

   localparam int RANDOM_ITEMS  = 244;
   localparam int SETTLE_CYCLES = 4;
   localparam int STALL_LIMIT   = 5000;

   // one result transfer as the block should present it
   typedef struct packed {
      logic [POS_W-1:0]  next_x;
      logic [POS_W-1:0]  next_y;
      logic              walk_over;
      logic              end_found;
      logic [PIX_W-1:0]  byte_out;
      logic              byte_valid;
      logic [PIX_W-1:0]  partial_byte;
      logic [BIDX_W-1:0] bit_position;
      logic              is_last;
   } walk_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [POS_W-1:0]      rsp_next_x;
   logic [POS_W-1:0]      rsp_next_y;
   logic                  rsp_walk_over;
   logic                  rsp_end_found;
   logic [PIX_W-1:0]      rsp_byte_out;
   logic                  rsp_byte_valid;
   logic [PIX_W-1:0]      rsp_partial_byte;
   logic [BIDX_W-1:0]     rsp_bit_position;
   logic                  rsp_is_last;

   spiral_lsb_message_extractor_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_x       (rsp_next_x),
      .rsp_next_y       (rsp_next_y),
      .rsp_walk_over    (rsp_walk_over),
      .rsp_end_found    (rsp_end_found),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_partial_byte (rsp_partial_byte),
      .rsp_bit_position (rsp_bit_position),
      .rsp_is_last      (rsp_is_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Walk predictor: settings, spiral position, packer and delay window
   // ------------------------------------------------------------------
   cfg_type          settings;
   int               walk_x, walk_y;
   int unsigned      leg_len, leg_done, win_fill, visited;
   dir_type          heading;
   bit               priming, halted, term_hit;
   logic [PIX_W-1:0] packing;
   logic [2:0]       pack_pos;
   logic [PIX_W-1:0] window [MAGIC_MAX];

   walk_result_type walk_outputs_due [$];
   int              live_items = 0;
   int              mismatch_count = 0;
   int unsigned     tick = 0;
   int unsigned     quiet_cycles = 0;

   function automatic int clamp_dim(input logic [DIM_W-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : int'(d);
   endfunction

   function automatic bit on_canvas(input int x, input int y);
      return x >= 0 && y >= 0 && x < clamp_dim(settings.img_width)
         && y < clamp_dim(settings.img_height);
   endfunction

   function automatic void restart_walk();
      walk_x   = clamp_dim(settings.img_width) / 2;
      walk_y   = clamp_dim(settings.img_height) / 2;
      leg_len  = 1;
      leg_done = 0;
      heading  = DIR_UP;
      priming  = 1'b1;
      halted   = 1'b0;
      term_hit = 1'b0;
      packing  = settings.start_byte;
      pack_pos = settings.start_bit_index;
      win_fill = 0;
      visited  = 0;
      foreach (window[k]) window[k] = '0;
   endfunction

   // a write to an unknown index changes nothing and does not restart
   function automatic void record_setting(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_IMG_WIDTH:       settings.img_width       = value[DIM_W-1:0];
         REG_IMG_HEIGHT:      settings.img_height      = value[DIM_W-1:0];
         REG_BITS_PER_PIXEL:  settings.bits_per_pixel  = value[BPP_W-1:0];
         REG_START_BIT_INDEX: settings.start_bit_index = value[BIDX_W-1:0];
         REG_START_BYTE:      settings.start_byte      = value[PIX_W-1:0];
         REG_MAGIC_WORD:      settings.magic_word      = value;
         REG_MAGIC_LENGTH:    settings.magic_length    = value[MLEN_W-1:0];
         REG_PIXEL_LIMIT:     settings.pixel_limit     = value[LIMIT_W-1:0];
         default:             return;
      endcase
      restart_walk();
   endfunction

   function automatic bit window_is_terminator(input int tlen);
      for (int k = 0; k < tlen; k++)
         if (window[k] != settings.magic_word[(tlen - 1 - k) * 8 +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void queue_result(input logic [PIX_W-1:0] b, input bit valid,
                                        input bit last);
      walk_result_type r;
      r.next_x       = halted ? '0 : POS_W'(walk_x);
      r.next_y       = halted ? '0 : POS_W'(walk_y);
      r.walk_over    = halted;
      r.end_found    = term_hit;
      r.byte_out     = valid ? b : '0;
      r.byte_valid   = valid;
      r.partial_byte = packing;
      r.bit_position = pack_pos;
      r.is_last      = last;
      walk_outputs_due.push_back(r);
   endfunction

   // consume one sample and queue every result it causes
   function automatic void advance_walk(input logic [PIX_W-1:0] pix);
      logic [PIX_W-1:0] emitted [$];
      logic [PIX_W-1:0] done_byte;
      int               nbits, tlen, i, k, nx, ny;
      if (halted) begin
         queue_result('0, 1'b0, 1'b1);
         return;
      end
      if (priming) begin
         priming = 1'b0;
         if (!on_canvas(walk_x, walk_y)) halted = 1'b1;
         queue_result('0, 1'b0, 1'b1);
         return;
      end
      nbits = (settings.bits_per_pixel > 8) ? 8 : int'(settings.bits_per_pixel);
      tlen  = (settings.magic_length > MAGIC_MAX) ? MAGIC_MAX : int'(settings.magic_length);
      for (i = nbits - 1; i >= 0; i--) begin
         packing[pack_pos] = pix[i];
         if (pack_pos != 0) begin
            pack_pos--;
            continue;
         end
         done_byte = packing;
         packing   = '0;
         pack_pos  = 3'd7;
         if (tlen == 0) begin
            emitted.push_back(done_byte);
            continue;
         end
         if (win_fill >= tlen) begin
            emitted.push_back(window[0]);
            for (k = 0; k < MAGIC_MAX - 1; k++) window[k] = window[k + 1];
            win_fill = tlen - 1;
         end
         window[win_fill % MAGIC_MAX] = done_byte;
         win_fill++;
         // rest of this sample is dropped once the terminator is seen
         if (win_fill == tlen && window_is_terminator(tlen)) begin
            term_hit = 1'b1;
            halted   = 1'b1;
            win_fill = 0;
            break;
         end
      end
      if (!halted) begin
         visited = (visited + 1) & 32'hFFFFF;
         if (visited >= settings.pixel_limit) begin
            halted = 1'b1;
         end else begin
            nx = walk_x;
            ny = walk_y;
            case (heading)
               DIR_UP:    ny--;
               DIR_RIGHT: nx++;
               DIR_DOWN:  ny++;
               default:   nx--;
            endcase
            leg_done++;
            if (leg_done >= leg_len) begin
               leg_done = 0;
               if (heading == DIR_RIGHT || heading == DIR_LEFT)
                  leg_len = (leg_len + 1) & 32'h1FFF;
               heading = dir_type'(2'(heading + 1));
            end
            if (on_canvas(nx, ny)) begin
               walk_x = nx;
               walk_y = ny;
            end else begin
               halted = 1'b1;
            end
         end
         // walk ended without the terminator: the window goes out as message
         if (halted) begin
            for (k = 0; k < win_fill && k < MAGIC_MAX && emitted.size() < QDEPTH; k++)
               emitted.push_back(window[k]);
            win_fill = 0;
         end
      end
      if (emitted.size() == 0) begin
         queue_result('0, 1'b0, 1'b1);
      end else begin
         for (k = 0; k < emitted.size(); k++)
            queue_result(emitted[k], 1'b1, k == emitted.size() - 1);
      end
   endfunction

   // ------------------------------------------------------------------
   // Idling: a 6 percent chance of a break, except in a quiet stretch every third window
   // ------------------------------------------------------------------
   always @(posedge clock) tick <= tick + 1;

   function automatic bit take_break();
      if (((tick / 250) % 3) == 1) return 1'b0;
      return $urandom_range(0, 99) < 6;
   endfunction

   always @(posedge clock) rsp_ready <= !take_break();

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      walk_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (walk_outputs_due.size() == 0) begin
            flag_mismatch("result transfer with nothing pending", 64'd1, 64'd0);
         end else begin
            want = walk_outputs_due.pop_front();
            if (rsp_next_x !== want.next_x)
               flag_mismatch("next_x", 64'(rsp_next_x), 64'(want.next_x));
            if (rsp_next_y !== want.next_y)
               flag_mismatch("next_y", 64'(rsp_next_y), 64'(want.next_y));
            if (rsp_walk_over !== want.walk_over)
               flag_mismatch("walk_over", 64'(rsp_walk_over), 64'(want.walk_over));
            if (rsp_end_found !== want.end_found)
               flag_mismatch("end_found", 64'(rsp_end_found), 64'(want.end_found));
            if (rsp_byte_out !== want.byte_out)
               flag_mismatch("byte_out", 64'(rsp_byte_out), 64'(want.byte_out));
            if (rsp_byte_valid !== want.byte_valid)
               flag_mismatch("byte_valid", 64'(rsp_byte_valid), 64'(want.byte_valid));
            if (rsp_partial_byte !== want.partial_byte)
               flag_mismatch("partial_byte", 64'(rsp_partial_byte),
                             64'(want.partial_byte));
            if (rsp_bit_position !== want.bit_position)
               flag_mismatch("bit_position", 64'(rsp_bit_position),
                             64'(want.bit_position));
            if (rsp_is_last !== want.is_last)
               flag_mismatch("is_last", 64'(rsp_is_last), 64'(want.is_last));
         end
      end
   end

   // watchdog: cycles in which no channel has a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("spiral_lsb_message_extractor_top_tb failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = 0;
      while (take_break()) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      live_items++;
      advance_walk(pix);
   endtask

   task automatic idle_requests();
      req_valid <= 1'b0;
   endtask

   // wait for every pending result, then let the block settle
   task automatic drain_results();
      while (walk_outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no low cycle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      record_setting(idx, value);
   endtask

   // writes all eight registers; noise lands in the bits above each register
   task automatic reprogram(input cfg_type c, input bit junk);
      logic [CSR_DATA_W-1:0] noise;
      drain_results();
      noise = junk ? {$urandom, $urandom} : '0;
      write_reg(REG_IMG_WIDTH,       {noise[CSR_DATA_W-1:DIM_W], c.img_width});
      write_reg(REG_IMG_HEIGHT,      {noise[CSR_DATA_W-1:DIM_W], c.img_height});
      write_reg(REG_BITS_PER_PIXEL,  {noise[CSR_DATA_W-1:BPP_W], c.bits_per_pixel});
      write_reg(REG_START_BIT_INDEX, {noise[CSR_DATA_W-1:BIDX_W], c.start_bit_index});
      write_reg(REG_START_BYTE,      {noise[CSR_DATA_W-1:PIX_W], c.start_byte});
      write_reg(REG_MAGIC_WORD,      c.magic_word);
      write_reg(REG_MAGIC_LENGTH,    {noise[CSR_DATA_W-1:MLEN_W], c.magic_length});
      write_reg(REG_PIXEL_LIMIT,     {noise[CSR_DATA_W-1:LIMIT_W], c.pixel_limit});
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // reset settings; the zero terminator needs eight zero bits, so no end yet
   task automatic test_reset_defaults();
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFE);
      idle_requests();
   endtask

   task automatic test_zero_dimension();
      cfg_type c;
      c = CFG_RESET;
      c.img_width = '0;
      reprogram(c, 1'b0);
      send_pixel(8'hA5);
      send_pixel(8'h5A);
      idle_requests();
   endtask

   // limit zero: the first sample after priming completes a byte, the walk stops and flushes it
   task automatic test_zero_pixel_limit();
      cfg_type c;
      c = CFG_RESET;
      c.pixel_limit    = '0;
      c.bits_per_pixel = 4'd8;
      c.magic_length   = 4'd2;
      reprogram(c, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'h81);
      send_pixel(8'hFF);
      idle_requests();
   endtask

   task automatic test_oversized_registers();
      cfg_type c;
      c = CFG_RESET;
      c.img_width       = 13'h1FFF;
      c.img_height      = 13'd4097;
      c.bits_per_pixel  = 4'hF;
      c.magic_length    = 4'hF;
      c.magic_word      = {$urandom, $urandom};
      c.start_bit_index = '0;
      c.start_byte      = 8'hAA;
      c.pixel_limit     = 20'hFFFFF;
      reprogram(c, 1'b1);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'h55);
      idle_requests();
   endtask

   task automatic test_zero_magic_length();
      cfg_type c;
      c = CFG_RESET;
      c.magic_length   = '0;
      c.bits_per_pixel = 4'd8;
      reprogram(c, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      idle_requests();
   endtask

   // no bits read: packer keeps the start byte, walk ends at the limit
   task automatic test_zero_bits_per_pixel();
      cfg_type c;
      c = CFG_RESET;
      c.bits_per_pixel  = '0;
      c.start_byte      = 8'h5A;
      c.start_bit_index = 3'd2;
      c.pixel_limit     = 20'd2;
      reprogram(c, 1'b0);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      idle_requests();
   endtask

   // byte completes halfway through the sample and matches; the low nibble is dropped
   task automatic test_terminator_mid_sample();
      cfg_type c;
      c = CFG_RESET;
      c.bits_per_pixel  = 4'd8;
      c.start_bit_index = 3'd3;
      c.start_byte      = 8'hC0;
      c.magic_word      = {$urandom, $urandom};
      c.magic_word[7:0] = 8'hC5;
      c.magic_length    = 4'd1;
      reprogram(c, 1'b0);
      send_pixel(8'h00);
      send_pixel(8'h5F);
      send_pixel(8'h12);
      idle_requests();
   endtask

   // 1x2 image: second step leaves the image and flushes two window bytes;
   // a write to an unknown index in between must not restart the walk
   task automatic test_edge_exit();
      cfg_type              c;
      logic [CSR_IDX_W-1:0] bad_idx;
      c = CFG_RESET;
      c.img_width      = 13'd1;
      c.img_height     = 13'd2;
      c.bits_per_pixel = 4'd8;
      c.magic_length   = 4'd8;
      c.magic_word     = {$urandom, $urandom};
      c.pixel_limit    = 20'd100;
      reprogram(c, 1'b0);
      send_pixel(8'h00);
      idle_requests();
      drain_results();
      bad_idx = CSR_IDX_W'(REG_PIXEL_LIMIT + $urandom_range(1, 8));
      write_reg(bad_idx, {$urandom, $urandom});
      csr_valid <= 1'b0;
      send_pixel(8'h3C);
      send_pixel(8'hC3);
      idle_requests();
   endtask

   // Mostly message walks (random payload then the terminator, encoded into
   // the low bits); the rest are short limit walks and tiny-image walks.
   task automatic test_random_walks();
      cfg_type          c;
      int               kind, tlen, nbits, extra, cap, k, start_count;
      logic [PIX_W-1:0] pix;
      bit               stream [$];
      start_count = live_items;
      while (live_items - start_count < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         c = CFG_RESET;
         c.bits_per_pixel  = BPP_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                                : $urandom_range(1, 8));
         c.start_bit_index = BIDX_W'($urandom);
         c.start_byte      = PIX_W'($urandom);
         c.magic_word      = {$urandom, $urandom};
         c.magic_length    = MLEN_W'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                                 : $urandom_range(1, 8));
         c.img_width       = DIM_W'($urandom_range(32, 300));
         c.img_height      = DIM_W'($urandom_range(32, 300));
         c.pixel_limit     = LIMIT_W'($urandom_range(1000, 20'hFFFFF));
         cap = 24;
         if (kind == 6 || kind == 7) begin
            c.bits_per_pixel = BPP_W'($urandom_range(0, 15));
            c.magic_length   = MLEN_W'($urandom_range(0, 15));
            c.pixel_limit    = LIMIT_W'($urandom_range(1, 20));
            c.img_width      = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(4096, 8191)
                                                                  : $urandom_range(1, 64));
            c.img_height     = DIM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(4096, 8191)
                                                                  : $urandom_range(1, 64));
         end else if (kind >= 8) begin
            c.bits_per_pixel = BPP_W'($urandom_range(0, 15));
            c.magic_length   = MLEN_W'($urandom_range(0, 15));
            c.img_width      = DIM_W'($urandom_range(0, 6));
            c.img_height     = DIM_W'($urandom_range(0, 6));
            cap = 48;
         end
         reprogram(c, 1'($urandom_range(0, 1)));

         stream.delete();
         if (kind < 6) begin
            tlen = (c.magic_length > MAGIC_MAX) ? MAGIC_MAX : int'(c.magic_length);
            repeat (c.start_bit_index + 1) stream.push_back(1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 5) * 8) stream.push_back(1'($urandom_range(0, 1)));
            for (k = tlen * 8 - 1; k >= 0; k--) stream.push_back(c.magic_word[k]);
         end
         nbits = (c.bits_per_pixel > 8) ? 8 : int'(c.bits_per_pixel);

         send_pixel(PIX_W'($urandom));
         extra = 0;
         while (!halted && extra < cap) begin
            pix = PIX_W'($urandom);
            for (k = nbits - 1; k >= 0; k--)
               if (stream.size() > 0) pix[k] = stream.pop_front();
            if (stream.size() == 0) extra++;
            send_pixel(pix);
         end
         if ($urandom_range(0, 1) == 1) send_pixel(PIX_W'($urandom));
         idle_requests();
      end
   endtask

   initial begin
      settings = CFG_RESET;
      restart_walk();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_dimension();
      test_zero_pixel_limit();
      test_oversized_registers();
      test_zero_magic_length();
      test_zero_bits_per_pixel();
      test_terminator_mid_sample();
      test_edge_exit();
      test_random_walks();

      idle_requests();
      while (walk_outputs_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("spiral_lsb_message_extractor_top_tb passed");
      else
         $display("spiral_lsb_message_extractor_top_tb failed");
      $finish;
   end

endmodule
